FILE: sv/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
// Used by sgm_ctrl, sgm_datapath and sobel_gradient_magnitude; depends on nothing.
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int WIDTH_W = 11;
  localparam int HEIGHT_W = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

  localparam int ROOT_STEPS = 8;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
    logic             frame_done;
  } result_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic square;
    logic sum;
    logic root;
    logic put;
  } ctrl_cmd_t;

  typedef struct packed {
    logic window_full;
    logic root_last;
    logic put_ok;
  } ctrl_status_t;

endpackage

FILE: sv/sgm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for the two line stores.
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sgm_ctrl.sv
// Controller state machine that sequences one pixel through the datapath.
// Depends on sgm_pkg for the command and status structs.
module sgm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  output sgm_pkg::ctrl_cmd_t    cmd,
  input  sgm_pkg::ctrl_status_t status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_PUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    pixel_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = status.window_full ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (status.root_last) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (status.put_ok) begin
          cmd.put    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/sgm_datapath.sv
// Datapath: position counters, line stores, window, Sobel sums, squares,
// bit-serial square root and the output register. Depends on sgm_pkg and sgm_ram.
module sgm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sgm_pkg::ctrl_cmd_t                  cmd,
  output sgm_pkg::ctrl_status_t               status,
  input  logic [sgm_pkg::WIDTH_W-1:0]         width_eff,
  input  logic [sgm_pkg::HEIGHT_W-1:0]        height_eff,
  input  sgm_pkg::pixel_t                     pixel_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output sgm_pkg::result_t                    result_data
);

  localparam int AW = $clog2(sgm_pkg::MAX_WIDTH);

  logic [sgm_pkg::COL_W-1:0] column_count;
  logic [sgm_pkg::ROW_W-1:0] row_count;
  logic [sgm_pkg::COL_W-1:0] col_in;
  logic [sgm_pkg::ROW_W-1:0] row_in;
  logic [sgm_pkg::COL_W-1:0] col_q;
  logic [sgm_pkg::ROW_W-1:0] row_q;
  logic [sgm_pkg::PIX_W-1:0] px_q;
  logic [sgm_pkg::PIX_W-1:0] win [6];
  logic [sgm_pkg::PIX_W-1:0] upper_rdata;
  logic [sgm_pkg::PIX_W-1:0] middle_rdata;

  logic [sgm_pkg::WIDTH_W-1:0]  col_inc;
  logic [sgm_pkg::HEIGHT_W-1:0] row_inc;

  logic signed [11:0] gx_full;
  logic signed [11:0] gy_full;
  logic signed [11:0] gx_div;
  logic signed [11:0] gy_div;
  logic signed [8:0]  gx_q;
  logic signed [8:0]  gy_q;
  logic signed [17:0] gx_prod;
  logic signed [17:0] gy_prod;
  logic [15:0]        sq_x;
  logic [15:0]        sq_y;
  logic [16:0]        radicand;

  logic                    done_q;
  logic                    sat_q;
  logic [15:0]             rad_sh;
  logic [8:0]              rem;
  logic [7:0]              root;
  logic [sgm_pkg::STEP_W-1:0] step;
  logic [10:0]             rem_sh;
  logic [10:0]             trial;

  // Position of the incoming pixel after frame start and size wrap.
  always_comb begin
    col_in = column_count;
    row_in = row_count;
    if (pixel_data.frame_start ||
        {1'b0, column_count} >= width_eff) begin
      col_in = '0;
    end
    if (pixel_data.frame_start ||
        {1'b0, row_count} >= height_eff) begin
      row_in = '0;
    end
  end

  sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(sgm_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col_q[AW-1:0]),
    .wdata (middle_rdata),
    .raddr (col_in[AW-1:0]),
    .rdata (upper_rdata)
  );

  sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(sgm_pkg::MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col_q[AW-1:0]),
    .wdata (px_q),
    .raddr (col_in[AW-1:0]),
    .rdata (middle_rdata)
  );

  assign col_inc = {1'b0, col_q} + 11'd1;
  assign row_inc = {1'b0, row_q} + 13'd1;

  // Window columns: win[0..2] oldest (top, middle, bottom), win[3..5] newer.
  always_comb begin
    gx_full = ($signed({4'b0, win[0]}) - $signed({4'b0, upper_rdata}))
            + (($signed({4'b0, win[1]}) - $signed({4'b0, middle_rdata})) <<< 1)
            + ($signed({4'b0, win[2]}) - $signed({4'b0, px_q}));
    gy_full = ($signed({4'b0, win[2]}) + ($signed({4'b0, win[5]}) <<< 1)
               + $signed({4'b0, px_q}))
            - ($signed({4'b0, win[0]}) + ($signed({4'b0, win[3]}) <<< 1)
               + $signed({4'b0, upper_rdata}));
    gx_div = gx_full[11] ? ((gx_full + 12'sd3) >>> 2) : (gx_full >>> 2);
    gy_div = gy_full[11] ? ((gy_full + 12'sd3) >>> 2) : (gy_full >>> 2);
  end

  assign gx_prod  = gx_q * gx_q;
  assign gy_prod  = gy_q * gy_q;
  assign radicand = {1'b0, sq_x} + {1'b0, sq_y};

  assign rem_sh = {rem, rad_sh[15:14]};
  assign trial  = {1'b0, root, 2'b01};

  assign status.window_full = (row_q >= 12'd2) && (col_q >= 10'd2);
  assign status.root_last   = (step == '0);
  assign status.put_ok      = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.calc) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= upper_rdata;
      win[4] <= middle_rdata;
      win[5] <= px_q;
      if (col_inc >= width_eff) begin
        column_count <= '0;
        row_count    <= (row_inc >= height_eff) ? '0 : row_inc[sgm_pkg::ROW_W-1:0];
      end else begin
        column_count <= col_inc[sgm_pkg::COL_W-1:0];
        row_count    <= row_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_q  <= pixel_data.pixel;
      col_q <= col_in;
      row_q <= row_in;
    end
    if (cmd.calc) begin
      gx_q   <= gx_div[8:0];
      gy_q   <= gy_div[8:0];
      done_q <= ({1'b0, row_q} == height_eff - 13'd1) &&
                ({1'b0, col_q} == width_eff - 11'd1);
    end
    if (cmd.square) begin
      sq_x <= gx_prod[15:0];
      sq_y <= gy_prod[15:0];
    end
    if (cmd.sum) begin
      sat_q  <= radicand[16];
      rad_sh <= radicand[15:0];
      rem    <= '0;
      root   <= '0;
      step   <= sgm_pkg::STEP_W'(sgm_pkg::ROOT_STEPS - 1);
    end else if (cmd.root) begin
      rad_sh <= {rad_sh[13:0], 2'b00};
      step   <= step - 1'b1;
      if (rem_sh >= trial) begin
        rem  <= 9'(rem_sh - trial);
        root <= {root[6:0], 1'b1};
      end else begin
        rem  <= rem_sh[8:0];
        root <= {root[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.put) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      result_data.magnitude  <= sat_q ? 8'hFF : root;
      result_data.centre_row <= row_q - 12'd1;
      result_data.centre_col <= col_q - 10'd1;
      result_data.frame_done <= done_q;
    end
  end

endmodule

FILE: sv/sobel_gradient_magnitude.sv
// Top level of the 3x3 Sobel gradient magnitude block: configuration
// registers, size clamping, and the controller and datapath instances.
// Depends on sgm_pkg, sgm_ctrl, sgm_datapath and sgm_ram.
//
// Pixels enter on the pixel channel in raster order, one transfer per pixel;
// frame_start on a pixel restarts the row and column count at zero.
// Each pixel that completes a 3x3 window gives one transfer on the result
// channel with the magnitude and the position of the window centre;
// border pixels give none. frame_done marks the last result of a frame.
// A pixel is taken in the idle state and its line store data used in the calc
// state; a window result then takes a square, a sum, the bit-serial square
// root and a put to the output register that waits on a stalled receiver.
// The block takes no new pixel until the last one has finished that sequence,
// since pixel_ready is high only while the controller is idle.
// The result is held in an output register; while the receiver stalls a
// new pixel is still taken and worked on up to the point of output.
// Reset (rst, synchronous) clears the counters, the window and the output
// valid, and sets width 640 and height 480; the line stores are not cleared.
// Width and height are written over the APB port at addresses 0 and 4.
module sobel_gradient_magnitude (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  sgm_pkg::pixel_t  pixel_data,
  output logic             result_valid,
  input  logic             result_ready,
  output sgm_pkg::result_t result_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  logic [sgm_pkg::WIDTH_W-1:0]  image_width;
  logic [sgm_pkg::HEIGHT_W-1:0] image_height;
  logic [sgm_pkg::WIDTH_W-1:0]  width_eff;
  logic [sgm_pkg::HEIGHT_W-1:0] height_eff;
  logic                         cfg_write;

  sgm_pkg::ctrl_cmd_t    cmd;
  sgm_pkg::ctrl_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sgm_pkg::WIDTH_RESET;
      image_height <= sgm_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH: begin
          image_width <= pwdata[sgm_pkg::WIDTH_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= pwdata[sgm_pkg::HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH: begin
        prdata = {{(32 - sgm_pkg::WIDTH_W){1'b0}}, image_width};
      end
      REG_IMAGE_HEIGHT: begin
        prdata = {{(32 - sgm_pkg::HEIGHT_W){1'b0}}, image_height};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_comb begin
    priority if (image_width < sgm_pkg::WIDTH_MIN) begin
      width_eff = sgm_pkg::WIDTH_MIN;
    end else if (image_width > sgm_pkg::WIDTH_MAX) begin
      width_eff = sgm_pkg::WIDTH_MAX;
    end else begin
      width_eff = image_width;
    end
    priority if (image_height < sgm_pkg::HEIGHT_MIN) begin
      height_eff = sgm_pkg::HEIGHT_MIN;
    end else if (image_height > sgm_pkg::HEIGHT_MAX) begin
      height_eff = sgm_pkg::HEIGHT_MAX;
    end else begin
      height_eff = image_height;
    end
  end

  sgm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .cmd         (cmd),
    .status      (status)
  );

  sgm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .width_eff    (width_eff),
    .height_eff   (height_eff),
    .pixel_data   (pixel_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

FILE: test/sgm_result_checker.sv
`timescale 1ns / 1ps
// Register address codes for the testbench and the result checker, which watches the
// pixel, result and APB channels, predicts each Sobel result and compares it field by
// field. Depends on sgm_pkg.
package sgm_tb_pkg;

  typedef enum logic [2:0] {
    REG_WIDTH_ADDR  = 3'd0,
    REG_HEIGHT_ADDR = 3'd4
  } reg_addr_t;

endpackage

module sgm_result_checker
  import sgm_pkg::*;
  import sgm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  input  logic        pixel_ready,
  input  pixel_t      pixel_data,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        end_of_run,
  output int          error_count,
  output int          pending_count,
  output int          results_checked,
  output int          frames_checked
);

  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]    window_cols [6];
  int                  col_pos;
  int                  row_pos;
  result_t             predicted_results [$];
  int                  fail_total = 0;
  int                  results_seen = 0;
  int                  frames_seen = 0;
  logic                tail_done = 1'b0;

  task automatic report_mismatch(input string msg);
    fail_total++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [PIX_W-1:0] saturated_root(input int sum_sq);
    int root;
    root = 0;
    for (int b = 9; b >= 0; b--) begin
      if ((root + (1 << b)) * (root + (1 << b)) <= sum_sq) root += (1 << b);
    end
    return (root > 255) ? {PIX_W{1'b1}} : PIX_W'(root);
  endfunction

  task automatic clear_predictor();
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_cols[i] = '0;
    col_pos = 0;
    row_pos = 0;
    predicted_results.delete();
  endtask

  task automatic step_window(input pixel_t px_in);
    int w, h, c, r;
    int t0, t1, t2, m0, m1, m2, b0, b1, b2, gx, gy;
    result_t res;
    w = (cfg_width < WIDTH_MIN) ? WIDTH_MIN : (cfg_width > WIDTH_MAX) ? WIDTH_MAX : cfg_width;
    h = (cfg_height < HEIGHT_MIN) ? HEIGHT_MIN :
        (cfg_height > HEIGHT_MAX) ? HEIGHT_MAX : cfg_height;
    if (px_in.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    t2 = upper_line[c];
    m2 = middle_line[c];
    b2 = px_in.pixel;
    if (r >= 2 && c >= 2) begin
      t0 = window_cols[0];
      m0 = window_cols[1];
      b0 = window_cols[2];
      t1 = window_cols[3];
      m1 = window_cols[4];
      b1 = window_cols[5];
      gx = ((t0 - t2) + 2 * (m0 - m2) + (b0 - b2)) / 4;
      gy = ((b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2)) / 4;
      res.magnitude = saturated_root(gx * gx + gy * gy);
      res.centre_row = ROW_W'(r - 1);
      res.centre_col = COL_W'(c - 1);
      res.frame_done = (r == h - 1) && (c == w - 1);
      predicted_results.push_back(res);
    end
    window_cols[0] = window_cols[3];
    window_cols[1] = window_cols[4];
    window_cols[2] = window_cols[5];
    window_cols[3] = PIX_W'(t2);
    window_cols[4] = PIX_W'(m2);
    window_cols[5] = px_in.pixel;
    upper_line[c] = middle_line[c];
    middle_line[c] = px_in.pixel;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result: magnitude %0d row %0d col %0d done %0b",
                                got.magnitude, got.centre_row, got.centre_col, got.frame_done));
      return;
    end
    want = predicted_results.pop_front();
    results_seen++;
    if (want.frame_done) frames_seen++;
    if (got.magnitude !== want.magnitude) begin
      report_mismatch($sformatf("magnitude at row %0d col %0d: got %0d, expected %0d",
                                want.centre_row, want.centre_col, got.magnitude, want.magnitude));
    end
    if (got.centre_row !== want.centre_row) begin
      report_mismatch($sformatf("centre_row: got %0d, expected %0d",
                                got.centre_row, want.centre_row));
    end
    if (got.centre_col !== want.centre_col) begin
      report_mismatch($sformatf("centre_col at row %0d: got %0d, expected %0d",
                                want.centre_row, got.centre_col, want.centre_col));
    end
    if (got.frame_done !== want.frame_done) begin
      report_mismatch($sformatf("frame_done at row %0d col %0d: got %0b, expected %0b",
                                want.centre_row, want.centre_col, got.frame_done,
                                want.frame_done));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_predictor();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_WIDTH_ADDR:  cfg_width = pwdata[WIDTH_W-1:0];
          REG_HEIGHT_ADDR: cfg_height = pwdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && pixel_ready) step_window(pixel_data);
      if (result_valid && result_ready) compare_result(result_data);
      if (end_of_run && !tail_done) begin
        tail_done = 1'b1;
        if (predicted_results.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    predicted_results.size()));
        end
      end
    end
    error_count <= fail_total;
    pending_count <= predicted_results.size();
    results_checked <= results_seen;
    frames_checked <= frames_seen;
  end

endmodule

FILE: test/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
// Testbench top for sobel_gradient_magnitude: clock, reset, APB size writes and a bursty
// pixel stream against a stalling result receiver. Depends on sgm_pkg and sgm_result_checker.
module sobel_gradient_magnitude_tb;
  import sgm_pkg::*;
  import sgm_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [9*PIX_W-1:0] FRAME_SATURATE = {8'd255, 8'd0,   8'd0,
                                                   8'd255, 8'd128, 8'd0,
                                                   8'd255, 8'd255, 8'd0};
  localparam logic [9*PIX_W-1:0] FRAME_TRUNCATE = {8'd0, 8'd9,   8'd3,
                                                   8'd0, 8'd200, 8'd0,
                                                   8'd0, 8'd0,   8'd0};
  localparam logic [9*PIX_W-1:0] FRAME_MIRROR   = {8'd0, 8'd0,  8'd255,
                                                   8'd0, 8'd77, 8'd255,
                                                   8'd0, 8'd0,  8'd0};

  typedef enum {STYLE_ANY, STYLE_EXTREME, STYLE_DIM} pixel_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_ready;
  pixel_t      pixel_data = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        run_done = 1'b0;

  int fail_count;
  int pending_count;
  int results_checked;
  int frames_checked;

  int burst_left = 0;
  int pixels_sent = 0;
  int eff_width = WIDTH_RESET;
  int col_track = 0;
  bit mid_written [MAX_WIDTH];
  bit up_written [MAX_WIDTH];
  int ready_hold = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sobel_gradient_magnitude u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_data   (pixel_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  sgm_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_ready     (pixel_ready),
    .pixel_data      (pixel_data),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_data     (result_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .end_of_run      (run_done),
    .error_count     (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .frames_checked  (frames_checked)
  );

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          result_ready <= 1'b1;
          ready_hold <= $urandom_range(10, 60);
        end
        1: begin
          result_ready <= 1'b0;
          ready_hold <= $urandom_range(1, 15);
        end
        default: begin
          result_ready <= 1'($urandom_range(0, 1));
          ready_hold <= $urandom_range(0, 2);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("No transfer for %0d cycles, %0d results still pending.",
               IDLE_LIMIT, pending_count);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void track_column(input logic first);
    if (first) col_track = 0;
    if (col_track >= eff_width) col_track = 0;
    up_written[col_track] = mid_written[col_track];
    mid_written[col_track] = 1'b1;
    col_track++;
    if (col_track >= eff_width) col_track = 0;
  endfunction

  function automatic bit stores_ready(input int width);
    for (int i = 0; i < width; i++) begin
      if (!up_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_style_t style);
    case (style)
      STYLE_EXTREME: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
      STYLE_DIM:     return PIX_W'($urandom_range(0, 15));
      default:       return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic hold_sender(input int cycles);
    pixel_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
    pixel_t next_px;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0) hold_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
    end
    next_px.pixel = value;
    next_px.frame_start = first;
    pixel_data <= next_px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    burst_left--;
    pixels_sent++;
    track_column(first);
  endtask

  task automatic send_frame9(input logic [9*PIX_W-1:0] frame, input logic first);
    for (int i = 0; i < 9; i++) begin
      send_pixel(frame[PIX_W*(8-i) +: PIX_W], first && (i == 0));
    end
  endtask

  task automatic stream_pixels(input int count, input logic first, input pixel_style_t style,
                               input bit noisy);
    logic mark;
    for (int i = 0; i < count; i++) begin
      mark = (i == 0) ? first : (noisy && $urandom_range(0, 59) == 0);
      send_pixel(pick_pixel(style), mark);
    end
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int raw_w, input int raw_h);
    hold_sender(1);
    wait_drained();
    write_reg(REG_WIDTH_ADDR, raw_w);
    write_reg(REG_HEIGHT_ADDR, raw_h);
    eff_width = raw_w & ((1 << WIDTH_W) - 1);
    if (eff_width < WIDTH_MIN) begin
      eff_width = WIDTH_MIN;
    end else if (eff_width > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end
    burst_left = 0;
  endtask

  initial begin
    int raw_w, raw_h, count;
    logic restart;
    pixel_style_t style;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size of 640x480 with counters starting at zero and no frame_start.
    stream_pixels(24, 1'b0, STYLE_ANY, 1'b0);

    // Smallest frame: saturation, wrap into a new frame, truncation toward zero,
    // and a frame_start in the middle of a line.
    configure(3, 3);
    send_frame9(FRAME_SATURATE, 1'b1);
    send_frame9(FRAME_TRUNCATE, 1'b0);
    send_pixel({PIX_W{1'b1}}, 1'b0);
    send_pixel('0, 1'b0);
    send_frame9(FRAME_MIRROR, 1'b1);

    // Out-of-range register values clamped: a narrow tall frame and the widest size.
    configure(0, 4096);
    stream_pixels(3 * 40, 1'b1, STYLE_ANY, 1'b0);
    configure(2047, 8191);
    stream_pixels(30, 1'b1, STYLE_EXTREME, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      configure(raw_w, raw_h);
      restart = $urandom_range(0, 1) || !stores_ready(eff_width);
      style = pixel_style_t'($urandom_range(0, 2));
      count = $urandom_range(30, 50);
      stream_pixels(count / 2, restart, style, 1'($urandom_range(0, 1)));
      if (ph == 3) begin
        hold_sender(1);
        wait_drained();
      end
      stream_pixels(count - count / 2, 1'b0, style, 1'($urandom_range(0, 1)));
    end

    hold_sender(1);
    wait_drained();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Sent %0d pixels; checked %0d results across %0d completed frames.",
             pixels_sent, results_checked, frames_checked);
    $display("Covered 3x3 frames, a clamped 3-wide tall stream, clamped widest size and");
    $display("random small sizes with mid-frame changes and frame restarts.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/sgm_pkg.sv
sv/sgm_ram.sv
sv/sgm_ctrl.sv
sv/sgm_datapath.sv
sv/sobel_gradient_magnitude.sv
test/sgm_result_checker.sv
test/sobel_gradient_magnitude_tb.sv
